// ===== rtl/mstp_pkg.sv =====
// ============================================================================
// mstp_pkg
// Shared types and constants for the minimum spanning tree core.
// ============================================================================
package mstp_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 32;
    localparam int SUM_BITS         = 48;

    // Request actions
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_START_VERTEX = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         vertex_a;
        logic [5:0]         vertex_b;
        logic signed [31:0] edge_weight;
    } mstp_in_t;

    typedef struct packed {
        logic [5:0]                 vertex_index;
        logic                       has_parent;
        logic [5:0]                 parent_vertex;
        logic signed [SUM_BITS-1:0] total_weight;
        logic                       all_reached;
        logic                       last;
    } mstp_out_t;

endpackage

// ===== rtl/mstp_ram.sv =====
// ============================================================================
// mstp_ram
// Single write port, single read port memory with registered read data.
// ============================================================================
module mstp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/min_spanning_tree_prim_core.sv =====
// ============================================================================
// min_spanning_tree_prim_core
// Prim minimum spanning tree over a dense adjacency store, with one shared
// compare/update unit sweeping one vertex per cycle.
// ============================================================================
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+------------------
//  in      | in_valid / in_ready / in_data    | input     | mstp_in_t request
//  out     | out_valid / out_ready / out_data | output    | mstp_out_t result
//  cfg     | cfg_valid / cfg_ready            | input     | cfg_index, cfg_data
//
// Add edge: read, compare, then two symmetric writes when the slot is empty or
// the new weight is lower; a dropped edge or an unused action is taken in idle.
// Clear: MAX_VERTICES*MAX_VERTICES entries (4096 by default), one store entry
// a cycle; the same clearing pass runs after reset before in_ready rises.
// Run: one sweep of n vertices per tree vertex through the single edge store
// read port, then S_OUT_RD, S_OUT_LD and S_OUT_WAIT per result plus out stalls.
// Configuration writes are taken every cycle.
// ============================================================================
module min_spanning_tree_prim_core
    import mstp_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mstp_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output mstp_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    typedef enum logic [9:0] {
        S_CLR      = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_ADD_RD   = 10'b0000000100,
        S_ADD_CHK  = 10'b0000001000,
        S_ADD_WR2  = 10'b0000010000,
        S_PICK     = 10'b0000100000,
        S_SCAN     = 10'b0001000000,
        S_OUT_RD   = 10'b0010000000,
        S_OUT_LD   = 10'b0100000000,
        S_OUT_WAIT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]                 vcount_reg, vcount_next;
    logic [5:0]                 start_reg, start_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic [VW-1:0]              va_reg, va_next;
    logic [VW-1:0]              vb_reg, vb_next;
    logic signed [WB-1:0]       w_reg, w_next;
    logic [MAX_VERTICES-1:0]    in_tree_reg, in_tree_next;
    logic [MAX_VERTICES-1:0]    bvalid_reg, bvalid_next;
    logic [MAX_VERTICES-1:0]    pvalid_reg, pvalid_next;
    logic [VW-1:0]              pick_reg, pick_next;
    logic signed [WB-1:0]       pcost_reg, pcost_next;
    logic [VW-1:0]              cv_reg, cv_next;
    logic                       found_reg, found_next;
    logic [VW-1:0]              minv_reg, minv_next;
    logic signed [WB-1:0]       minc_reg, minc_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [NW-1:0]              count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;
    mstp_out_t                  out_reg, out_next;

    logic [NW-1:0] n_eff;
    logic          root_ok;
    logic          edge_ok;
    logic          cv_last;
    logic          ov_last;

    // Edge store and per-vertex memories
    logic          e_we;
    logic [AW-1:0] e_waddr, e_raddr;
    logic [WB:0]   e_wdata, e_rdata;
    logic          b_we;
    logic [VW-1:0] b_raddr;
    logic [WB-1:0] b_rdata;
    logic [VW-1:0] p_rdata;

    logic                 e_pres;
    logic signed [WB-1:0] e_cost;
    logic signed [WB-1:0] b_cost;
    logic                 upd;
    logic                 nvalid;
    logic signed [WB-1:0] ncost;
    logic                 cand;
    logic signed [SUM_BITS:0] sum_ext;

    mstp_ram #(.DEPTH(DEPTH), .WIDTH(WB + 1)) u_edge (
        .clk     (clk),
        .wr_en   (e_we),
        .wr_addr (e_waddr),
        .wr_data (e_wdata),
        .rd_addr (e_raddr),
        .rd_data (e_rdata)
    );

    mstp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(WB)) u_best (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (cv_reg),
        .wr_data (e_cost),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    mstp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_parent (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (cv_reg),
        .wr_data (pick_reg),
        .rd_addr (cv_reg),
        .rd_data (p_rdata)
    );

    // Clamp vertex count, check root and edge endpoints
    always_comb
    begin
        if (vcount_reg == 7'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(vcount_reg) > MAX_VERTICES)
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(vcount_reg);
        end
        root_ok = 32'(start_reg) < 32'(n_eff);
        edge_ok = (32'(in_data.vertex_a) < MAX_VERTICES)
               && (32'(in_data.vertex_b) < MAX_VERTICES)
               && (in_data.vertex_a != in_data.vertex_b);
        cv_last = (NW'(cv_reg) + NW'(1)) == n_eff;
        ov_last = cv_last;
    end

    // Shared compare/update unit for one swept vertex
    always_comb
    begin
        e_pres  = e_rdata[WB];
        e_cost  = e_rdata[WB-1:0];
        b_cost  = b_rdata;
        upd     = !in_tree_reg[cv_reg] && e_pres
               && (!bvalid_reg[cv_reg] || (e_cost < b_cost));
        nvalid  = bvalid_reg[cv_reg] || upd;
        ncost   = upd ? e_cost : b_cost;
        cand    = !in_tree_reg[cv_reg] && nvalid && (!found_reg || (ncost < minc_reg));
        sum_ext = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(pcost_reg);
    end

    // Memory port selection
    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = clr_reg;
        e_wdata = '0;
        e_raddr = AW'(32'(va_reg) * MAX_VERTICES + 32'(vb_reg));
        b_raddr = '0;
        b_we    = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                e_we = 1'b1;
            end
            S_ADD_CHK:
            begin
                e_we    = !e_rdata[WB] || (w_reg < $signed(e_rdata[WB-1:0]));
                e_waddr = AW'(32'(va_reg) * MAX_VERTICES + 32'(vb_reg));
                e_wdata = {1'b1, w_reg};
            end
            S_ADD_WR2:
            begin
                e_we    = 1'b1;
                e_waddr = AW'(32'(vb_reg) * MAX_VERTICES + 32'(va_reg));
                e_wdata = {1'b1, w_reg};
            end
            S_PICK:
            begin
                e_raddr = AW'(32'(pick_reg) * MAX_VERTICES);
            end
            S_SCAN:
            begin
                e_raddr = AW'(32'(pick_reg) * MAX_VERTICES + 32'(cv_reg) + 1);
                b_raddr = VW'(32'(cv_reg) + 1);
                b_we    = upd;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = vcount_reg;
        start_next     = start_reg;
        clr_next       = clr_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        w_next         = w_reg;
        in_tree_next   = in_tree_reg;
        bvalid_next    = bvalid_reg;
        pvalid_next    = pvalid_reg;
        pick_next      = pick_reg;
        pcost_next     = pcost_reg;
        cv_next        = cv_reg;
        found_next     = found_reg;
        minv_next      = minv_reg;
        minc_next      = minc_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // Take configuration writes at any time
        if (cfg_valid)
        begin
            if (cfg_index == CFG_VERTEX_COUNT)
            begin
                vcount_next = cfg_data;
            end
            else
            begin
                start_next = cfg_data[5:0];
            end
        end

        unique case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    va_next = VW'(in_data.vertex_a);
                    vb_next = VW'(in_data.vertex_b);
                    w_next  = in_data.edge_weight[WB-1:0];
                    unique case (in_data.action)
                        ACT_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        ACT_ADD:
                        begin
                            if (edge_ok)
                            begin
                                state_next = S_ADD_RD;
                            end
                        end
                        ACT_RUN:
                        begin
                            in_tree_next = '0;
                            bvalid_next  = '0;
                            pvalid_next  = '0;
                            sum_next     = '0;
                            count_next   = '0;
                            cv_next      = '0;
                            pick_next    = VW'(start_reg);
                            pcost_next   = '0;
                            state_next   = root_ok ? S_PICK : S_OUT_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_CHK;
            end
            S_ADD_CHK:
            begin
                state_next = e_we ? S_ADD_WR2 : S_IDLE;
            end
            S_ADD_WR2:
            begin
                state_next = S_IDLE;
            end
            S_PICK:
            begin
                // Join the picked vertex and accumulate with saturation
                in_tree_next[pick_reg] = 1'b1;
                bvalid_next[pick_reg]  = 1'b1;
                count_next             = count_reg + NW'(1);
                if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1])
                begin
                    sum_next = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
                end
                else
                begin
                    sum_next = sum_ext[SUM_BITS-1:0];
                end
                found_next = 1'b0;
                cv_next    = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Relax one vertex and track the lowest open cost
                if (upd)
                begin
                    bvalid_next[cv_reg] = 1'b1;
                    pvalid_next[cv_reg] = 1'b1;
                end
                if (cand)
                begin
                    found_next = 1'b1;
                    minv_next  = cv_reg;
                    minc_next  = ncost;
                end
                cv_next = cv_reg + VW'(1);
                if (cv_last)
                begin
                    cv_next = '0;
                    if (cand)
                    begin
                        pick_next  = cv_reg;
                        pcost_next = ncost;
                        state_next = S_PICK;
                    end
                    else if (found_reg)
                    begin
                        pick_next  = minv_reg;
                        pcost_next = minc_reg;
                        state_next = S_PICK;
                    end
                    else
                    begin
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                out_next.vertex_index  = 6'(cv_reg);
                out_next.has_parent    = pvalid_reg[cv_reg];
                out_next.parent_vertex = pvalid_reg[cv_reg] ? 6'(p_rdata) : 6'd0;
                out_next.total_weight  = ov_last ? sum_reg : '0;
                out_next.all_reached   = ov_last && (count_reg == n_eff);
                out_next.last          = ov_last;
                out_valid_next         = 1'b1;
                state_next             = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    cv_next        = cv_reg + VW'(1);
                    state_next     = out_reg.last ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            vcount_reg    <= 7'd1;
            start_reg     <= 6'd0;
            clr_reg       <= '0;
            in_tree_reg   <= '0;
            bvalid_reg    <= '0;
            pvalid_reg    <= '0;
            cv_reg        <= '0;
            found_reg     <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            start_reg     <= start_next;
            clr_reg       <= clr_next;
            in_tree_reg   <= in_tree_next;
            bvalid_reg    <= bvalid_next;
            pvalid_reg    <= pvalid_next;
            cv_reg        <= cv_next;
            found_reg     <= found_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        w_reg     <= w_next;
        pick_reg  <= pick_next;
        pcost_reg <= pcost_next;
        minv_reg  <= minv_next;
        minc_reg  <= minc_next;
        out_reg   <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
